// ===== hdl/cdca_pkg.sv =====
// shared types, constants and calendar helpers for the day count block
package cdca_pkg;

  localparam int MAX_YEAR_DEF = 9999;
  localparam int EPOCH_YEAR   = 1901;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  localparam int SERIAL_W = 22;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int WDAY_W   = 3;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture input transaction
    logic invalidate;  // clear held date
    logic init_set;    // start year walk for a set
    logic init_from;   // start year walk from a serial
    logic yr_step;
    logic mon_step;
    logic commit_set;
    logic commit_from;
    logic emit;        // load output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic range_ok;
    logic serial_zero;
    logic add_over;
    logic sub_big;
    logic sub_zero;
    logic year_hit;
    logic year_fits;
    logic mon_hit;
    logic day_ok;
    logic mon_more;
  } dp_sts_t;

  function automatic int leaps_upto(input int x);
    return x / 4 - x / 100 + x / 400;
  endfunction

  // days from 1 jan 1901 to 1 jan of year y, elaboration only
  function automatic int days_before_year(input int y);
    return (y - EPOCH_YEAR) * 365 + leaps_upto(y - 1) - leaps_upto(EPOCH_YEAR - 1);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // 8 is 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [SERIAL_W-1:0] v);
    logic [23:0] p;
    logic [5:0]  s;
    logic [3:0]  r;
    logic [2:0]  q;
    p = {2'b00, v};
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(p[3*i +: 3]);
    end
    r = 4'(s[5:3]) + 4'(s[2:0]);
    q = 3'(r[3]) + r[2:0];
    return (q == 3'd7) ? 3'd0 : q;
  endfunction

endpackage

// ===== hdl/cdca_ctrl.sv =====
// sequencer for the day count block: dispatch, year and month walks, output handoff
module cdca_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  cdca_pkg::dp_sts_t   sts,
  output cdca_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SET_YEAR, S_SET_MON, S_FROM_YEAR, S_FROM_MON, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_EMIT;
        case (sts.op)
          cdca_pkg::OP_SET: begin
            if (!sts.range_ok) begin
              cmd.invalidate = 1'b1;
            end else begin
              cmd.init_set = 1'b1;
              state_nxt    = S_SET_YEAR;
            end
          end
          cdca_pkg::OP_ADD: begin
            if (!sts.serial_zero) begin
              if (sts.add_over) begin
                cmd.invalidate = 1'b1;
              end else begin
                cmd.init_from = 1'b1;
                state_nxt     = S_FROM_YEAR;
              end
            end
          end
          cdca_pkg::OP_SUB: begin
            if (!sts.serial_zero && !sts.sub_big) begin
              if (sts.sub_zero) begin
                cmd.invalidate = 1'b1;
              end else begin
                cmd.init_from = 1'b1;
                state_nxt     = S_FROM_YEAR;
              end
            end
          end
          default: ;
        endcase
      end
      S_SET_YEAR: begin
        if (sts.year_hit) begin
          state_nxt = S_SET_MON;
        end else begin
          cmd.yr_step = 1'b1;
        end
      end
      S_SET_MON: begin
        if (sts.mon_hit) begin
          cmd.commit_set = sts.day_ok;
          cmd.invalidate = !sts.day_ok;
          state_nxt      = S_EMIT;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      S_FROM_YEAR: begin
        if (sts.year_fits) begin
          state_nxt = S_FROM_MON;
        end else begin
          cmd.yr_step = 1'b1;
        end
      end
      S_FROM_MON: begin
        if (sts.mon_more) begin
          cmd.mon_step = 1'b1;
        end else begin
          cmd.commit_from = 1'b1;
          state_nxt       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/cdca_dp.sv =====
// datapath: held date, shared year and month walker, output register
module cdca_dp #(
  parameter int MAX_YEAR = cdca_pkg::MAX_YEAR_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [cdca_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [cdca_pkg::IN_USER_W-1:0]      in_tuser,
  output logic [cdca_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  cdca_pkg::dp_cmd_t                   cmd,
  output cdca_pkg::dp_sts_t                   sts
);

  localparam int SW = cdca_pkg::SERIAL_W;
  localparam int YW = cdca_pkg::YEAR_W;
  localparam int MW = cdca_pkg::MONTH_W;
  localparam int DW = cdca_pkg::DAY_W;
  localparam logic [SW:0]   LAST     = (SW+1)'(cdca_pkg::days_before_year(MAX_YEAR + 1));
  localparam logic [YW-1:0] YEAR_MAX = YW'(MAX_YEAR);
  localparam logic [YW-1:0] YEAR_MIN = YW'(cdca_pkg::EPOCH_YEAR);

  // latched transaction
  logic [1:0]    op_r;
  logic [DW-1:0] sd_r;
  logic [MW-1:0] sm_r;
  logic [YW-1:0] sy_r;
  logic [SW-1:0] cnt_r;

  // walker
  logic          mode_set_r;
  logic [SW-1:0] x_r, x_nxt;
  logic [SW-1:0] s_r;
  logic [YW-1:0] y_r;
  logic [6:0]    m100_r;
  logic [8:0]    m400_r;
  logic [MW-1:0] mon_r;

  // held date
  logic [SW-1:0] serial_r;
  logic [DW-1:0] day_r;
  logic [MW-1:0] month_r;
  logic [YW-1:0] year_r;

  logic [cdca_pkg::OUT_DATA_W-1:0] out_data_r;

  logic          leap;
  logic [8:0]    ylen;
  logic [DW-1:0] dim;
  logic [SW:0]   sum;
  logic [SW-1:0] diff;
  logic [2:0]    wmod;
  logic [2:0]    wday;

  assign leap = (m400_r == 9'd0) || ((m100_r != 7'd0) && (y_r[1:0] == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign dim  = cdca_pkg::month_days(mon_r, leap);
  assign sum  = {1'b0, serial_r} + {1'b0, cnt_r};
  assign diff = serial_r - cnt_r;
  assign wmod = cdca_pkg::mod7(serial_r);
  assign wday = (serial_r == '0) ? 3'd0 : ((wmod == 3'd6) ? 3'd1 : wmod + 3'd2);

  always_comb begin
    sts.op          = op_r;
    sts.range_ok    = (sy_r >= YEAR_MIN) && (sy_r <= YEAR_MAX) && (sm_r != '0) &&
                      (sm_r <= MW'(12)) && (sd_r != '0);
    sts.serial_zero = (serial_r == '0);
    sts.add_over    = (sum > LAST);
    sts.sub_big     = (cnt_r > serial_r);
    sts.sub_zero    = (diff == '0);
    sts.year_hit    = (y_r == sy_r);
    sts.year_fits   = (x_r <= SW'(ylen));
    sts.mon_hit     = (mon_r == sm_r);
    sts.day_ok      = (sd_r <= dim);
    sts.mon_more    = (mon_r < MW'(12)) && (x_r > SW'(dim));
  end

  always_comb begin
    x_nxt = x_r;
    if (cmd.init_set) begin
      x_nxt = '0;
    end else if (cmd.init_from) begin
      x_nxt = (op_r == cdca_pkg::OP_ADD) ? sum[SW-1:0] : diff;
    end else if (cmd.yr_step) begin
      x_nxt = mode_set_r ? x_r + SW'(ylen) : x_r - SW'(ylen);
    end else if (cmd.mon_step) begin
      x_nxt = mode_set_r ? x_r + SW'(dim) : x_r - SW'(dim);
    end
  end

  // walker and latch, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_tuser;
      sd_r  <= in_tdata[4:0];
      sm_r  <= in_tdata[8:5];
      sy_r  <= in_tdata[22:9];
      cnt_r <= in_tdata[44:23];
    end
    x_r <= x_nxt;
    if (cmd.init_set || cmd.init_from) begin
      mode_set_r <= cmd.init_set;
      s_r        <= (op_r == cdca_pkg::OP_ADD) ? sum[SW-1:0] : diff;
      y_r        <= YEAR_MIN;
      m100_r     <= 7'd1;
      m400_r     <= 9'd301;
      mon_r      <= MW'(1);
    end else if (cmd.yr_step) begin
      y_r    <= y_r + YW'(1);
      m100_r <= (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
      m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
    end else if (cmd.mon_step) begin
      mon_r <= mon_r + MW'(1);
    end
    if (cmd.emit) begin
      out_data_r <= {7'd0, serial_r, wday, year_r, month_r, day_r, (serial_r != '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serial_r <= '0;
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
    end else if (cmd.invalidate) begin
      serial_r <= '0;
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
    end else if (cmd.commit_set) begin
      serial_r <= x_r + SW'(sd_r);
      day_r    <= sd_r;
      month_r  <= sm_r;
      year_r   <= sy_r;
    end else if (cmd.commit_from) begin
      serial_r <= s_r;
      day_r    <= x_r[DW-1:0];
      month_r  <= mon_r;
      year_r   <= y_r;
    end
  end

  assign out_tdata = out_data_r;

  a_held_month_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (serial_r != '0) |-> (month_r != '0 && month_r <= MW'(12) && day_r != '0))
    else $error("held date has bad month or day");

  a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (serial_r == '0) |-> (day_r == '0 && month_r == '0 && year_r == '0))
    else $error("invalid state not all zero");

  a_held_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    (serial_r != '0) |-> (year_r >= YEAR_MIN && year_r <= YEAR_MAX))
    else $error("held year out of range");

  a_walk_counters: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.yr_step) |-> (m100_r < 7'd100 && m400_r < 9'd400))
    else $error("leap counters out of range");

endmodule

// ===== hdl/calendar_day_count_arithmetic.sv =====
// top level: gregorian date held as a serial day number, set, add and subtract
// operation: set walks the years from 1901 up to the set year, then the months; add and
// subtract walk the result serial down through the years, then through the months
// throughput: one transaction at a time; the shared walker steps one year per cycle, then
// one month per cycle
// reset: synchronous active-low rst_n clears the held date to the invalid all-zero state
module calendar_day_count_arithmetic #(
  parameter int MAX_YEAR = cdca_pkg::MAX_YEAR_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // set_day[4:0], set_month[8:5], set_year[22:9], day_count[44:23], zero pad
  input  logic [cdca_pkg::IN_DATA_W-1:0]      in_tdata,
  // op[1:0]
  input  logic [cdca_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // date_valid[0], day_of_month[5:1], month_number[9:6], year_number[23:10],
  // weekday[26:24], serial_day[48:27], zero pad
  output logic [cdca_pkg::OUT_DATA_W-1:0]     out_tdata
);

  cdca_pkg::dp_cmd_t cmd;
  cdca_pkg::dp_sts_t sts;

  cdca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cdca_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== dv/calendar_day_count_arithmetic_tb.sv =====
// testbench for the calendar day count block: directed and random dates, scoreboard check
`timescale 1ns / 100ps

module tb;

  localparam int          DW          = cdca_pkg::DAY_W;
  localparam int          MW          = cdca_pkg::MONTH_W;
  localparam int          YW          = cdca_pkg::YEAR_W;
  localparam int          WW          = cdca_pkg::WDAY_W;
  localparam int          SW          = cdca_pkg::SERIAL_W;
  localparam int          MAX_YR      = cdca_pkg::MAX_YEAR_DEF;
  localparam int unsigned FIRST_YEAR  = 1901;
  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam int          NUM_RANDOM  = 75;
  localparam int          DRAIN_CYCLES = 200;
  // worst case is every transaction walking to the last year, with margin
  localparam longint      CYCLE_LIMIT = 5_000_000;

  typedef struct packed {
    logic          valid;
    logic [DW-1:0] dom;
    logic [MW-1:0] month;
    logic [YW-1:0] year;
    logic [WW-1:0] wday;
    logic [SW-1:0] serial;
  } date_word_t;

  class date_scoreboard;
    int unsigned serial;
    int unsigned cur_day;
    int unsigned cur_month;
    int unsigned cur_year;
    int unsigned last_serial;
    int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    date_word_t  expected_q[$];
    int          errors;

    function new();
      errors = 0;
      clear();
      last_serial = days_to_jan1(MAX_YR + 1);
    endfunction

    function bit is_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function int unsigned days_in_month(int unsigned y, int unsigned m);
      if (m == 2 && is_leap(y)) return 29;
      return month_len[(m - 1) % 12];
    endfunction

    function int unsigned days_to_jan1(int unsigned y);
      int unsigned total;
      total = 0;
      for (int unsigned yr = FIRST_YEAR; yr < y; yr++) total += is_leap(yr) ? 366 : 365;
      return total;
    endfunction

    function void clear();
      serial    = 0;
      cur_day   = 0;
      cur_month = 0;
      cur_year  = 0;
    endfunction

    function void walk_serial(int unsigned s);
      int unsigned rest;
      int unsigned y;
      int unsigned m;
      rest = s;
      y    = FIRST_YEAR;
      m    = 1;
      while (rest > (is_leap(y) ? 366 : 365)) begin
        rest -= is_leap(y) ? 366 : 365;
        y++;
      end
      while (m < 12 && rest > days_in_month(y, m)) begin
        rest -= days_in_month(y, m);
        m++;
      end
      serial    = s;
      cur_day   = rest;
      cur_month = m;
      cur_year  = y;
    endfunction

    function void load_date(int unsigned d, int unsigned m, int unsigned y);
      int unsigned s;
      if (y < FIRST_YEAR || y > MAX_YR || m < 1 || m > 12 || d < 1 ||
          d > days_in_month(y, m)) begin
        clear();
        return;
      end
      s = days_to_jan1(y);
      for (int unsigned k = 1; k < m; k++) s += days_in_month(y, k);
      serial    = s + d;
      cur_day   = d;
      cur_month = m;
      cur_year  = y;
    endfunction

    function void note_input(logic [1:0] op, logic [4:0] d, logic [3:0] m,
                             logic [13:0] y, logic [21:0] cnt);
      date_word_t  want;
      int unsigned wd;
      int unsigned c;
      c = 32'(cnt);
      case (op)
        cdca_pkg::OP_SET: load_date(32'(d), 32'(m), 32'(y));
        cdca_pkg::OP_ADD: begin
          if (serial != 0) begin
            if (serial + c > last_serial) clear();
            else walk_serial(serial + c);
          end
        end
        cdca_pkg::OP_SUB: begin
          if (serial != 0 && c <= serial) begin
            if (c == serial) clear();
            else walk_serial(serial - c);
          end
        end
        default: ;
      endcase
      wd = 0;
      if (serial != 0) begin
        wd = 2 + serial % 7;
        if (wd > 7) wd = 1;
      end
      want.valid  = (serial != 0);
      want.dom    = DW'(cur_day);
      want.month  = MW'(cur_month);
      want.year   = YW'(cur_year);
      want.wday   = WW'(wd);
      want.serial = SW'(serial);
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [cdca_pkg::OUT_DATA_W-1:0] word);
      date_word_t got;
      date_word_t want;
      got.valid  = word[0];
      got.dom    = word[5:1];
      got.month  = word[9:6];
      got.year   = word[23:10];
      got.wday   = word[26:24];
      got.serial = word[48:27];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with nothing expected: %h", $time, word);
        return;
      end
      want = expected_q.pop_front();
      compare_field("date_valid", 32'(want.valid), 32'(got.valid));
      compare_field("day_of_month", 32'(want.dom), 32'(got.dom));
      compare_field("month_number", 32'(want.month), 32'(got.month));
      compare_field("year_number", 32'(want.year), 32'(got.year));
      compare_field("weekday", 32'(want.wday), 32'(got.wday));
      compare_field("serial_day", 32'(want.serial), 32'(got.serial));
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [cdca_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [cdca_pkg::IN_USER_W-1:0]  in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cdca_pkg::OUT_DATA_W-1:0] out_tdata;

  int                    tx_idle_pct = 7;
  int                    rx_idle_pct = 83;
  longint                cycle_cnt   = 0;
  date_scoreboard        sb;

  calendar_day_count_arithmetic dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("calendar_day_count_arithmetic regression: fail");
      $finish;
    end
  end

  // valid is left high after a transaction so back-to-back ones need no second assignment
  task automatic send_txn(input logic [1:0] op, input logic [4:0] d, input logic [3:0] m,
                          input logic [13:0] y, input logic [21:0] cnt);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, cnt, y, m, d};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, d, m, y, cnt);
  endtask

  task automatic send_random_txn();
    int unsigned pick;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned cnt;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // well-formed date, mostly near the epoch to keep the year walk short
      y = ($urandom_range(0, 19) == 0) ? $urandom_range(FIRST_YEAR, MAX_YR)
                                       : $urandom_range(FIRST_YEAR, 1960);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, sb.days_in_month(y, m));
      send_txn(cdca_pkg::OP_SET, DW'(d), MW'(m), YW'(y), SW'($urandom_range(0, 4194303)));
    end else if (pick < 40) begin
      y = $urandom_range(0, 1) ? $urandom_range(0, 16383) : $urandom_range(1890, 1970);
      send_txn(cdca_pkg::OP_SET, DW'($urandom_range(0, 31)), MW'($urandom_range(0, 15)),
               YW'(y), SW'($urandom_range(0, 4194303)));
    end else if (pick < 65) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4194303) : $urandom_range(0, 3000);
      send_txn(cdca_pkg::OP_ADD, DW'($urandom_range(0, 31)), MW'($urandom_range(0, 15)),
               YW'($urandom_range(0, 16383)), SW'(cnt));
    end else if (pick < 90) begin
      // mostly counts around the held serial so subtract to zero and too far both occur
      if (sb.serial != 0 && $urandom_range(0, 4) != 0) cnt = $urandom_range(0, sb.serial + 2);
      else cnt = $urandom_range(0, 4194303);
      send_txn(cdca_pkg::OP_SUB, DW'($urandom_range(0, 31)), MW'($urandom_range(0, 15)),
               YW'($urandom_range(0, 16383)), SW'(cnt));
    end else begin
      send_txn(OP_NONE, DW'($urandom_range(0, 31)), MW'($urandom_range(0, 15)),
               YW'($urandom_range(0, 16383)), SW'($urandom_range(0, 4194303)));
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // operations on the invalid reset state
    send_txn(cdca_pkg::OP_ADD, 0, 0, 0, 5);
    send_txn(cdca_pkg::OP_SUB, 0, 0, 0, 1);
    send_txn(OP_NONE, 0, 0, 0, 0);
    // first day, then subtract to zero
    send_txn(cdca_pkg::OP_SET, 1, 1, 1901, 0);
    send_txn(cdca_pkg::OP_SUB, 0, 0, 0, 1);
    send_txn(cdca_pkg::OP_SET, 31, 12, 1901, 0);
    send_txn(cdca_pkg::OP_SUB, 0, 0, 0, 366);
    send_txn(cdca_pkg::OP_SUB, 0, 0, 0, 364);
    send_txn(cdca_pkg::OP_ADD, 0, 0, 0, 0);
    send_txn(cdca_pkg::OP_SUB, 0, 0, 0, 0);
    // last day, then one past the range
    send_txn(cdca_pkg::OP_SET, 31, 12, YW'(MAX_YR), 0);
    send_txn(cdca_pkg::OP_ADD, 0, 0, 0, 1);
    // leap rule corners
    send_txn(cdca_pkg::OP_SET, 29, 2, 2000, 0);
    send_txn(cdca_pkg::OP_SET, 29, 2, 2100, 0);
    send_txn(cdca_pkg::OP_SET, 29, 2, 2004, 0);
    send_txn(cdca_pkg::OP_SET, 29, 2, 2003, 0);
    // bad fields on set
    send_txn(cdca_pkg::OP_SET, 31, 4, 2020, 0);
    send_txn(cdca_pkg::OP_SET, 0, 5, 1950, 0);
    send_txn(cdca_pkg::OP_SET, 10, 0, 1950, 0);
    send_txn(cdca_pkg::OP_SET, 10, 13, 1950, 0);
    send_txn(cdca_pkg::OP_SET, 31, 1, 1900, 0);
    send_txn(cdca_pkg::OP_SET, 31, 1, YW'(MAX_YR + 1), 0);
    send_txn(cdca_pkg::OP_SET, 31, 15, 16383, 4194303);
    // full-scale counts on a valid date
    send_txn(cdca_pkg::OP_SET, 15, 6, 1930, 0);
    send_txn(cdca_pkg::OP_SUB, 0, 0, 0, 4194303);
    send_txn(OP_NONE, 31, 15, 16383, 4194303);
    send_txn(cdca_pkg::OP_ADD, 0, 0, 0, 4194303);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 3) begin
        tx_idle_pct = 83;
        rx_idle_pct = 7;
      end else if (i == 2 * NUM_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random_txn();
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("calendar_day_count_arithmetic regression: pass");
    end else begin
      $display("calendar_day_count_arithmetic regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cdca_pkg.sv
hdl/cdca_ctrl.sv
hdl/cdca_dp.sv
hdl/calendar_day_count_arithmetic.sv
dv/calendar_day_count_arithmetic_tb.sv
